// File: design/cor_pkg.sv
// Shared constants and point-order helpers for the circle octant rasterizer.
package cor_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam int DEC_EXTRA  = 6;
  localparam int OUT_EXTRA  = 2;

  localparam int POINTS_PER_STEP = 8;
  localparam int POINT_IDX_W     = $clog2(POINTS_PER_STEP);
  localparam logic [POINT_IDX_W-1:0] LAST_POINT = POINT_IDX_W'(POINTS_PER_STEP - 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Point order: bit 0 negates the first offset, bit 1 the second, bit 2 swaps x and y.
  function automatic logic point_neg_x(input logic [POINT_IDX_W-1:0] k);
    point_neg_x = k[0];
  endfunction

  function automatic logic point_neg_y(input logic [POINT_IDX_W-1:0] k);
    point_neg_y = k[1];
  endfunction

  function automatic logic point_swap(input logic [POINT_IDX_W-1:0] k);
    point_swap = k[2];
  endfunction

endpackage

// File: design/cor_front.sv
// Front end: accepts start and step transactions and runs the midpoint recurrence.
module cor_front #(
  parameter int COORD_BITS = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic                      opcode,
  input  logic [COORD_BITS-1:0]     center_x,
  input  logic [COORD_BITS-1:0]     center_y,
  input  logic [COORD_BITS-1:0]     radius,
  output logic                      desc_push,
  output logic [4*COORD_BITS:0]     desc_data
);

  localparam int DW = COORD_BITS + cor_pkg::DEC_EXTRA;

  logic [COORD_BITS-1:0] x_r, x_nxt;
  logic [COORD_BITS-1:0] y_r, y_nxt;
  logic [COORD_BITS-1:0] cx_r, cx_nxt;
  logic [COORD_BITS-1:0] cy_r, cy_nxt;
  logic signed [DW-1:0]  d_r, d_nxt;
  logic                  active_r, active_nxt;

  logic [DW-1:0] nx_d;
  logic [DW-1:0] ny_d;
  logic [DW-1:0] nd_d;
  logic          d_pos;
  logic          done;
  logic          is_step;

  assign is_step = (opcode == cor_pkg::OP_STEP);
  assign d_pos   = (d_r > 0);
  assign nx_d    = DW'(x_r) + DW'(1);
  assign ny_d    = d_pos ? (DW'(y_r) - DW'(1)) : DW'(y_r);
  assign nd_d    = d_pos ? (DW'(d_r) + ((nx_d - ny_d) << 2) + DW'(10))
                         : (DW'(d_r) + (nx_d << 2) + DW'(6));
  assign done    = ($signed(ny_d) < $signed(nx_d));

  assign desc_push = accept && is_step && active_r;
  assign desc_data = {done, cx_r, cy_r, x_r, y_r};

  always_comb begin
    x_nxt      = x_r;
    y_nxt      = y_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    d_nxt      = d_r;
    active_nxt = active_r;
    if (accept && !is_step) begin
      cx_nxt     = center_x;
      cy_nxt     = center_y;
      x_nxt      = '0;
      y_nxt      = radius;
      d_nxt      = $signed(DW'(3) - (DW'(radius) << 1));
      active_nxt = 1'b1;
    end else if (desc_push) begin
      x_nxt = nx_d[COORD_BITS-1:0];
      y_nxt = ny_d[COORD_BITS-1:0];
      d_nxt = $signed(nd_d);
      if (done) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r  <= x_nxt;
    y_r  <= y_nxt;
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
    d_r  <= d_nxt;
  end

endmodule

// File: design/cor_queue.sv
// Short step queue between the front end and the point generator.
module cor_queue #(
  parameter int WIDTH = 41
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0]              entries_r [cor_pkg::QUEUE_DEPTH];
  logic [cor_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [cor_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [cor_pkg::QPTR_W:0]      count_r, count_nxt;

  assign full      = (count_r == (cor_pkg::QPTR_W+1)'(cor_pkg::QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign head_data = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (cor_pkg::QPTR_W+1)'(push) - (cor_pkg::QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/cor_back.sv
// Back end: expands each queued step into its eight mirrored points.
module cor_back #(
  parameter int COORD_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [4*COORD_BITS:0]              desc_data,
  input  logic                               desc_empty,
  output logic                               desc_pop,
  input  logic                               out_pop,
  output logic                               out_empty,
  output logic signed [COORD_BITS+1:0]       out_point_x,
  output logic signed [COORD_BITS+1:0]       out_point_y,
  output logic                               out_last_of_step,
  output logic                               out_arc_finished
);

  localparam int OW = COORD_BITS + cor_pkg::OUT_EXTRA;

  logic [cor_pkg::POINT_IDX_W-1:0] k_r, k_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [OW-1:0]                   px_r, px_nxt;
  logic [OW-1:0]                   py_r, py_nxt;
  logic                            last_r, last_nxt;
  logic                            fin_r, fin_nxt;

  logic                  done;
  logic [COORD_BITS-1:0] cx, cy, x, y, ox, oy;
  logic                  advance;
  logic                  is_last;

  assign {done, cx, cy, x, y} = desc_data;

  assign advance  = !desc_empty && (!out_valid_r || out_pop);
  assign is_last  = (k_r == cor_pkg::LAST_POINT);
  assign desc_pop = advance && is_last;

  assign ox = cor_pkg::point_swap(k_r) ? y : x;
  assign oy = cor_pkg::point_swap(k_r) ? x : y;

  always_comb begin
    px_nxt        = px_r;
    py_nxt        = py_r;
    last_nxt      = last_r;
    fin_nxt       = fin_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      px_nxt        = cor_pkg::point_neg_x(k_r) ? (OW'(cx) - OW'(ox)) : (OW'(cx) + OW'(ox));
      py_nxt        = cor_pkg::point_neg_y(k_r) ? (OW'(cy) - OW'(oy)) : (OW'(cy) + OW'(oy));
      last_nxt      = is_last;
      fin_nxt       = is_last && done;
      k_nxt         = k_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    last_r <= last_nxt;
    fin_r  <= fin_nxt;
  end

  assign out_empty        = !out_valid_r;
  assign out_point_x      = $signed(px_r);
  assign out_point_y      = $signed(py_r);
  assign out_last_of_step = last_r;
  assign out_arc_finished = fin_r;

endmodule

// File: design/circle_octant_rasterizer.sv
// Midpoint circle rasterizer top level: front end, step queue and point generator.
//
// Input channel (push/full): a transaction carries an opcode and, for a start,
// the center and radius. A start loads a new circle and yields no
// points; it drops any circle still in progress. A step yields the eight
// mirrored points of the current octant position and then advances it; a step
// with no circle in progress yields nothing.
// Result channel (empty/pop): one point per transaction, oldest first. The
// eighth point of a step has last_of_step set, and arc_finished as well on the
// final step of the circle.
// The first point of a step is registered in the point generator after the step
// has passed through the step queue. Throughput: one point per cycle while the
// receiver pops, set by the single point generator. A two-entry step queue lets
// the front end take new transactions while the generator works.
// Reset empties the queue and the result register and leaves no circle active.
// When the receiver stalls, the result holds, the queue fills and full rises.
module circle_octant_rasterizer #(
  parameter int COORD_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic                         in_opcode,
  input  logic [COORD_BITS-1:0]        in_center_x,
  input  logic [COORD_BITS-1:0]        in_center_y,
  input  logic [COORD_BITS-1:0]        in_radius,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COORD_BITS+1:0] out_point_x,
  output logic signed [COORD_BITS+1:0] out_point_y,
  output logic                         out_last_of_step,
  output logic                         out_arc_finished
);

  localparam int DESC_W = 4 * COORD_BITS + 1;

  logic              accept;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  logic [DESC_W-1:0] q_in_data;
  logic [DESC_W-1:0] q_head_data;

  assign full   = q_full;
  assign accept = push && !q_full;

  cor_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .opcode    (in_opcode),
    .center_x  (in_center_x),
    .center_y  (in_center_y),
    .radius    (in_radius),
    .desc_push (q_push),
    .desc_data (q_in_data)
  );

  cor_queue #(
    .WIDTH(DESC_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in_data),
    .pop       (q_pop),
    .head_data (q_head_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  cor_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .desc_data        (q_head_data),
    .desc_empty       (q_empty),
    .desc_pop         (q_pop),
    .out_pop          (pop),
    .out_empty        (empty),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_last_of_step (out_last_of_step),
    .out_arc_finished (out_arc_finished)
  );

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("step queue written while full");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> !q_empty)
    else $error("queued step lost");

  a_fin_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_arc_finished) |-> out_last_of_step)
    else $error("arc end flagged on a point that is not the last of its step");

endmodule
